// File: hdl/tfup_pkg.sv
package tfup_pkg;

    // header layout
    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned POS_KIND  = 4;
    localparam int unsigned POS_CNT_H = 6;
    localparam int unsigned POS_CNT_L = 7;

    // magic word, byte 0 first
    localparam logic [7:0] MAGIC_0 = 8'h50;
    localparam logic [7:0] MAGIC_1 = 8'h32;
    localparam logic [7:0] MAGIC_2 = 8'h56;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    // packet kinds
    localparam logic [7:0] KIND_FULL  = 8'd1;
    localparam logic [7:0] KIND_TILES = 8'd2;

    // status codes
    typedef enum logic [1:0] {
        STATUS_PENDING  = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_TILES    = 2'd3
    } status_t;

    // where we are inside one tile record
    typedef enum logic [1:0] {
        REC_X   = 2'd0,
        REC_Y   = 2'd1,
        REC_PIX = 2'd2
    } rec_phase_t;

endpackage

// File: hdl/tile_frame_update_parser_core.sv
// Tile frame update parser. Takes a video update packet one byte per item on
// the slave side and returns exactly one result item per input item on the
// master side: a byte write to an RGB565 frame store (write_valid, address,
// data) and, on the last byte of a packet, the status. Each packet starts with
// a 16-byte header (magic P2V1, kind, big-endian tile count); kind 1 is a full
// frame, kind 2 a list of tile records (x byte, y byte, TILE_SIZE lines of
// 2*TILE_SIZE bytes). A bad tile coordinate stops further writes and rejects
// the packet. The block is a two-register pipeline (input register, result
// register) and takes one item every cycle while the master side does not
// stall; each accepted item goes through the input register and then the
// result register. Tile addresses are kept in a running address register that
// the y byte of each record loads, so pixel bytes need no multiply.
module tile_frame_update_parser_core #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int TILE_SIZE    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], packet_length[25:8], zero pad
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // write_valid[0], frame_addr[18:1], write_data[26:19],
                                   // status[28:27], zero pad
    output logic        m_tlast    // packet_done
);

    localparam int unsigned LINE_BYTES = 2 * TILE_SIZE;
    localparam int unsigned REC_BYTES  = 2 + 2 * TILE_SIZE * TILE_SIZE;
    localparam int unsigned TILES_X    = FRAME_WIDTH / TILE_SIZE;
    localparam int unsigned TILES_Y    = FRAME_HEIGHT / TILE_SIZE;
    localparam int unsigned TILES_MAX  = TILES_X * TILES_Y;
    localparam longint unsigned FULL_LEN =
        longint'(tfup_pkg::HDR_BYTES) + longint'(FRAME_WIDTH) * FRAME_HEIGHT * 2;
    localparam int unsigned ROW_STRIDE  = 2 * FRAME_WIDTH;
    localparam int unsigned TILE_STRIDE = TILE_SIZE * ROW_STRIDE;
    localparam int unsigned LINE_JUMP   = ROW_STRIDE - LINE_BYTES + 1;

    localparam int REC_W  = $clog2(REC_BYTES + 1);
    localparam int PROD_W = 16 + REC_W;
    localparam int FULL_W = $clog2(FULL_LEN + 1);
    localparam int CMP_W  = (PROD_W > FULL_W ? PROD_W : FULL_W) + 1;
    localparam int FA_W   = $clog2(FRAME_WIDTH * FRAME_HEIGHT * 2);
    localparam int ADDR_W = FA_W > 18 ? FA_W : 18;
    localparam int ROW_W  = $clog2(TILE_SIZE);
    localparam int COL_W  = $clog2(LINE_BYTES);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_first_reg;
    logic [17:0] in_len_reg;

    // result register
    logic        out_valid_reg;
    logic        out_wv_reg;
    logic [17:0] out_addr_reg;
    logic [7:0]  out_wdata_reg;
    logic        out_done_reg;
    logic [1:0]  out_status_reg;

    // parser state
    logic [17:0]            pos_reg,    pos_next;
    logic [17:0]            size_reg,   size_next;
    logic [7:0]             kind_reg,   kind_next;
    logic [15:0]            total_reg,  total_next;
    logic [7:0]             tcol_reg,   tcol_next;
    logic                   fault_reg,  fault_next;
    tfup_pkg::rec_phase_t   phase_reg,  phase_next;
    logic [ROW_W-1:0]       row_reg,    row_next;
    logic [COL_W-1:0]       col_reg,    col_next;
    logic [ADDR_W-1:0]      addr_reg,   addr_next;

    // result of the current item
    logic        wv_c;
    logic [17:0] addr_c;
    logic        done_c;
    logic [1:0]  status_c;

    logic out_free;
    logic adv;

    // handshake chain
    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || adv;

    // per-byte parse
    always_comb
    begin
        logic [17:0]       p;
        logic [17:0]       size_eff;
        logic              hdr_ok;
        logic [PROD_W-1:0] tile_len;
        logic [17:0]       off;

        pos_next   = pos_reg;
        size_next  = size_reg;
        kind_next  = kind_reg;
        total_next = total_reg;
        tcol_next  = tcol_reg;
        fault_next = fault_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        addr_next  = addr_reg;
        wv_c       = 1'b0;
        addr_c     = '0;
        done_c     = 1'b0;
        status_c   = tfup_pkg::STATUS_PENDING;
        size_eff   = (in_len_reg == '0) ? 18'd1 : in_len_reg;

        // a new packet clears the parser state, but not the running address
        if (in_first_reg)
        begin
            pos_next   = '0;
            size_next  = size_eff;
            kind_next  = '0;
            total_next = '0;
            tcol_next  = '0;
            fault_next = (size_eff < 18'(tfup_pkg::HDR_BYTES));
            phase_next = tfup_pkg::REC_X;
            row_next   = '0;
            col_next   = '0;
        end

        p        = pos_next;
        off      = p - 18'(tfup_pkg::HDR_BYTES);
        tile_len = PROD_W'(total_next) * PROD_W'(REC_BYTES);

        // header check uses kind and count stored by earlier bytes
        if (kind_next == tfup_pkg::KIND_FULL)
        begin
            hdr_ok = (total_next == '0) && (CMP_W'(size_next) == CMP_W'(FULL_LEN));
        end
        else if (kind_next == tfup_pkg::KIND_TILES)
        begin
            hdr_ok = (32'(total_next) <= 32'(TILES_MAX)) &&
                     (CMP_W'(size_next) ==
                      CMP_W'(tfup_pkg::HDR_BYTES) + CMP_W'(tile_len));
        end
        else
        begin
            hdr_ok = 1'b0;
        end

        if (p < size_next)
        begin
            // header fields
            if (p == 18'd0 && in_data_reg != tfup_pkg::MAGIC_0) fault_next = 1'b1;
            if (p == 18'd1 && in_data_reg != tfup_pkg::MAGIC_1) fault_next = 1'b1;
            if (p == 18'd2 && in_data_reg != tfup_pkg::MAGIC_2) fault_next = 1'b1;
            if (p == 18'd3 && in_data_reg != tfup_pkg::MAGIC_3) fault_next = 1'b1;
            if (p == 18'(tfup_pkg::POS_KIND))  kind_next  = in_data_reg;
            if (p == 18'(tfup_pkg::POS_CNT_H)) total_next = {in_data_reg, 8'h00};
            if (p == 18'(tfup_pkg::POS_CNT_L)) total_next = {total_reg[15:8], in_data_reg};
            if (p == 18'(tfup_pkg::HDR_BYTES - 1) && !hdr_ok) fault_next = 1'b1;

            // payload
            if (p >= 18'(tfup_pkg::HDR_BYTES) && !fault_next)
            begin
                if (kind_next == tfup_pkg::KIND_FULL)
                begin
                    wv_c   = 1'b1;
                    addr_c = off;
                end
                else
                begin
                    unique case (phase_reg)
                        tfup_pkg::REC_X:
                        begin
                            tcol_next  = in_data_reg;
                            phase_next = tfup_pkg::REC_Y;
                        end
                        tfup_pkg::REC_Y:
                        begin
                            if (32'(tcol_reg) >= 32'(TILES_X) ||
                                32'(in_data_reg) >= 32'(TILES_Y))
                                fault_next = 1'b1;
                            addr_next  = ADDR_W'(ADDR_W'(in_data_reg) * ADDR_W'(TILE_STRIDE))
                                       + ADDR_W'(ADDR_W'(tcol_reg) * ADDR_W'(LINE_BYTES));
                            phase_next = tfup_pkg::REC_PIX;
                            row_next   = '0;
                            col_next   = '0;
                        end
                        tfup_pkg::REC_PIX:
                        begin
                            wv_c   = 1'b1;
                            addr_c = addr_reg[17:0];
                            if (col_reg == COL_W'(LINE_BYTES - 1))
                            begin
                                col_next  = '0;
                                addr_next = addr_reg + ADDR_W'(LINE_JUMP);
                                if (row_reg == ROW_W'(TILE_SIZE - 1))
                                begin
                                    row_next   = '0;
                                    phase_next = tfup_pkg::REC_X;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next  = col_reg + 1'b1;
                                addr_next = addr_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = tfup_pkg::REC_X;
                        end
                    endcase
                end
            end

            // final byte
            if (p == size_next - 1'b1)
            begin
                done_c = 1'b1;
                if (fault_next)
                    status_c = tfup_pkg::STATUS_REJECTED;
                else if (kind_next == tfup_pkg::KIND_FULL)
                    status_c = tfup_pkg::STATUS_FULL;
                else
                    status_c = tfup_pkg::STATUS_TILES;
                pos_next = size_next;
            end
            else
            begin
                pos_next = p + 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[25:8];
            in_first_reg <= s_tuser;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            size_reg  <= '0;
            kind_reg  <= '0;
            total_reg <= '0;
            tcol_reg  <= '0;
            fault_reg <= 1'b0;
            phase_reg <= tfup_pkg::REC_X;
            row_reg   <= '0;
            col_reg   <= '0;
            addr_reg  <= '0;
        end
        else if (adv)
        begin
            pos_reg   <= pos_next;
            size_reg  <= size_next;
            kind_reg  <= kind_next;
            total_reg <= total_next;
            tcol_reg  <= tcol_next;
            fault_reg <= fault_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            addr_reg  <= addr_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_wv_reg     <= wv_c;
            out_addr_reg   <= wv_c ? addr_c : 18'd0;
            out_wdata_reg  <= wv_c ? in_data_reg : 8'd0;
            out_done_reg   <= done_c;
            out_status_reg <= status_c;
        end
    end

    // master side
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_wdata_reg, out_addr_reg, out_wv_reg};

endmodule
